// ===== hdl/csps_pkg.sv =====
`timescale 1ns / 1ps
package csps_pkg;

    localparam int STEP_WIDTH = 12;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET = 12'd112;

    // Fraction position of the coordinates. Every computed bit is the same
    // for any fraction position, so no datapath width depends on it.
    localparam int FRAC_BITS = 4;

    // Control flags that travel with each transaction through the pipeline.
    typedef struct packed {
        logic        valid;
        logic        arrived;
        logic        neg_x;
        logic        neg_y;
    } csps_ctl_t;

endpackage

// ===== hdl/constant_speed_point_stepper.sv =====
`timescale 1ns / 1ps
// Constant speed point stepper.
// The input channel (in_valid / in_stall) carries one transaction per object:
// current and destination position, signed fixed point. The output channel
// (out_valid / out_stall) returns the stepped position and an arrival flag.
// The block moves the point by step_length along the straight line to the
// destination, clamping each axis that would reach or overshoot.
// Throughput is one transaction per cycle unless the receiver stalls. The
// stages are differencing, squaring, COORD_WIDTH+2 of square root,
// COORD_WIDTH+STEP_WIDTH+1 of division and one output stage,
// 2*COORD_WIDTH+STEP_WIDTH+6 in all (58 at the defaults). The whole pipeline
// advances together; when the receiver stalls with a result waiting, every
// stage holds and in_stall is raised, so nothing is lost or repeated. Empty
// slots hold as well, so no input is taken then. Reset clears all valid bits
// and loads step_length with seven units. The user writes step_length through
// cfg_we / cfg_data only while the block is idle (not enforced by the block).
module constant_speed_point_stepper #(
    parameter int COORD_WIDTH = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [csps_pkg::STEP_WIDTH-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [COORD_WIDTH-1:0]        cur_x,
    input  logic signed [COORD_WIDTH-1:0]        cur_y,
    input  logic signed [COORD_WIDTH-1:0]        dst_x,
    input  logic signed [COORD_WIDTH-1:0]        dst_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [COORD_WIDTH-1:0]        next_x,
    output logic signed [COORD_WIDTH-1:0]        next_y,
    output logic                                 arrived
);
    import csps_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;          // |difference| width
    localparam int SW  = 2 * DW + 1;               // sum of squares
    localparam int RW  = DW + 1;                   // root width
    localparam int NW  = DW + STEP_WIDTH;          // product width
    localparam int LAT = 2 + RW + NW + 1;          // total stages

    logic [STEP_WIDTH-1:0] step_reg;
    logic                  adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_RESET;
        else if (cfg_we)
            step_reg <= cfg_data;
    end

    // Control travels alongside the data, one entry per stage.
    csps_ctl_t             ctl_reg  [LAT];
    logic [COORD_WIDTH-1:0] cx_reg [LAT];
    logic [COORD_WIDTH-1:0] cy_reg [LAT];
    logic [COORD_WIDTH-1:0] tx_reg [LAT];
    logic [COORD_WIDTH-1:0] ty_reg [LAT];
    logic [DW-1:0]          ax_reg [LAT];
    logic [DW-1:0]          ay_reg [LAT];
    logic [STEP_WIDTH-1:0]  st_reg [LAT];

    assign adv      = !(ctl_reg[LAT-1].valid && out_stall);
    assign in_stall = !adv;

    // Stage 0: differences.
    logic signed [DW-1:0] dx_c, dy_c;
    csps_ctl_t            ctl_in;
    always_comb
    begin
        dx_c = DW'(dst_x) - DW'(cur_x);
        dy_c = DW'(dst_y) - DW'(cur_y);
        ctl_in.valid   = in_valid;
        ctl_in.arrived = (cur_x == dst_x) && (cur_y == dst_y);
        ctl_in.neg_x   = dx_c[DW-1];
        ctl_in.neg_y   = dy_c[DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                ctl_reg[i] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < LAT; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= cur_x;
            cy_reg[0] <= cur_y;
            tx_reg[0] <= dst_x;
            ty_reg[0] <= dst_y;
            ax_reg[0] <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
            ay_reg[0] <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
            st_reg[0] <= step_reg;
            for (int i = 1; i < LAT; i++)
            begin
                cx_reg[i] <= cx_reg[i-1];
                cy_reg[i] <= cy_reg[i-1];
                tx_reg[i] <= tx_reg[i-1];
                ty_reg[i] <= ty_reg[i-1];
                ax_reg[i] <= ax_reg[i-1];
                ay_reg[i] <= ay_reg[i-1];
                st_reg[i] <= st_reg[i-1];
            end
        end
    end

    // Stage 1: squares and sum.
    logic [SW-1:0] sq_sum_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            sq_sum_reg <= SW'(ax_reg[0] * ax_reg[0]) + SW'(ay_reg[0] * ay_reg[0]);
    end

    // Stages 2 .. RW+1: root.
    logic [RW-1:0] root;
    csps_sqrt #(.RootWidth(RW)) u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand ({1'b0, sq_sum_reg}),
        .root     (root)
    );

    localparam int PS = RW + 1;  // stage whose data meets the root
    logic [RW-1:0] len_c;
    assign len_c = (root == '0) ? RW'(1) : root;

    logic [NW-1:0] px_c, py_c;
    assign px_c = NW'(ax_reg[PS] * st_reg[PS]);
    assign py_c = NW'(ay_reg[PS] * st_reg[PS]);

    logic [NW-1:0] qx, qy;
    csps_div #(.NumWidth(NW), .DenWidth(RW)) u_div_x (
        .clk (clk), .en (adv), .numer (px_c), .denom (len_c), .quot (qx)
    );
    csps_div #(.NumWidth(NW), .DenWidth(RW)) u_div_y (
        .clk (clk), .en (adv), .numer (py_c), .denom (len_c), .quot (qy)
    );

    // Final stage: clamp and apply sign.
    localparam int FS = PS + NW;
    logic [COORD_WIDTH-1:0] nx_c, ny_c;
    always_comb
    begin
        if (ctl_reg[FS].arrived || (qx >= NW'(ax_reg[FS])))
            nx_c = tx_reg[FS];
        else if (ctl_reg[FS].neg_x)
            nx_c = cx_reg[FS] - qx[COORD_WIDTH-1:0];
        else
            nx_c = cx_reg[FS] + qx[COORD_WIDTH-1:0];
        if (ctl_reg[FS].arrived || (qy >= NW'(ay_reg[FS])))
            ny_c = ty_reg[FS];
        else if (ctl_reg[FS].neg_y)
            ny_c = cy_reg[FS] - qy[COORD_WIDTH-1:0];
        else
            ny_c = cy_reg[FS] + qy[COORD_WIDTH-1:0];
    end

    logic [COORD_WIDTH-1:0] nx_reg, ny_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= nx_c;
            ny_reg <= ny_c;
        end
    end

    assign out_valid = ctl_reg[LAT-1].valid;
    assign arrived   = ctl_reg[LAT-1].arrived;
    assign next_x    = nx_reg;
    assign next_y    = ny_reg;
endmodule

// ===== hdl/csps_sqrt.sv =====
`timescale 1ns / 1ps
module csps_sqrt #(
    parameter int RootWidth = 21
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [2*RootWidth-1:0]   radicand,
    output logic [RootWidth-1:0]     root
);
    import csps_pkg::*;

    // One result bit per stage, restoring square root on the remainder.
    logic [2*RootWidth-1:0] rad_reg  [RootWidth+1];
    logic [RootWidth-1:0]   res_reg  [RootWidth+1];
    logic [RootWidth+1:0]   rem_reg  [RootWidth+1];

    always_comb
    begin
        rad_reg[0] = radicand;
        res_reg[0] = '0;
        rem_reg[0] = '0;
    end

    genvar g;
    generate
        for (g = 0; g < RootWidth; g++)
        begin : g_stage
            logic [RootWidth+1:0] rem_shift;
            logic [RootWidth+1:0] trial;
            logic [RootWidth+1:0] rem_next;
            logic [RootWidth-1:0] res_next;
            always_comb
            begin
                rem_shift = {rem_reg[g][RootWidth-1:0],
                             rad_reg[g][2*RootWidth-1 -: 2]};
                trial = {res_reg[g], 2'b01};
                if (rem_shift >= trial)
                begin
                    rem_next = rem_shift - trial;
                    res_next = {res_reg[g][RootWidth-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift;
                    res_next = {res_reg[g][RootWidth-2:0], 1'b0};
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[g+1] <= {rad_reg[g][2*RootWidth-3:0], 2'b00};
                    res_reg[g+1] <= res_next;
                    rem_reg[g+1] <= rem_next;
                end
            end
        end
    endgenerate

    assign root = res_reg[RootWidth];
endmodule

// ===== hdl/csps_div.sv =====
`timescale 1ns / 1ps
module csps_div #(
    parameter int NumWidth = 33,
    parameter int DenWidth = 21
) (
    input  logic                clk,
    input  logic                en,
    input  logic [NumWidth-1:0] numer,
    input  logic [DenWidth-1:0] denom,
    output logic [NumWidth-1:0] quot
);
    import csps_pkg::*;

    // Restoring division, one quotient bit per stage.
    logic [NumWidth-1:0] num_reg [NumWidth+1];
    logic [DenWidth-1:0] den_reg [NumWidth+1];
    logic [DenWidth:0]   rem_reg [NumWidth+1];

    always_comb
    begin
        num_reg[0] = numer;
        den_reg[0] = denom;
        rem_reg[0] = '0;
    end

    genvar g;
    generate
        for (g = 0; g < NumWidth; g++)
        begin : g_stage
            logic [DenWidth+1:0] sh;
            logic [DenWidth:0]   rem_next;
            logic                bit_q;
            always_comb
            begin
                sh = {rem_reg[g], num_reg[g][NumWidth-1]};
                bit_q = (sh >= {2'b00, den_reg[g]});
                if (bit_q)
                    sh = sh - {2'b00, den_reg[g]};
                rem_next = sh[DenWidth:0];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[g+1] <= {num_reg[g][NumWidth-2:0], bit_q};
                    den_reg[g+1] <= den_reg[g];
                    rem_reg[g+1] <= rem_next;
                end
            end
        end
    endgenerate

    assign quot = num_reg[NumWidth];
endmodule

// ===== hdl/csps_checker.sv =====
`timescale 1ns / 1ps
module csps_checker #(
    parameter int COORD_WIDTH = 20
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [COORD_WIDTH-1:0] next_x,
    input logic                   arrived
);
    import csps_pkg::*;

    // A stall on the input only arises from a waiting, stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(next_x) && $stable(arrived)))
        else $error("stalled result changed");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");
endmodule

bind constant_speed_point_stepper csps_checker #(.COORD_WIDTH(COORD_WIDTH)) u_csps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_x    (next_x),
    .arrived   (arrived)
);
